// ===== design/c_subset_lexer_top_defines.svh =====
// Assertion macros for the C subset lexer.
`ifndef C_SUBSET_LEXER_TOP_DEFINES_SVH
`define C_SUBSET_LEXER_TOP_DEFINES_SVH

`ifndef SYNTH
`define CSL_ASSERT_NOW(lbl, clk_i, rst_i, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (pre) |-> (post)) \
    else $error("c_subset_lexer: assertion failed");
`define CSL_ASSERT_NEXT(lbl, clk_i, rst_i, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (pre) |=> (post)) \
    else $error("c_subset_lexer: assertion failed");
`else
`define CSL_ASSERT_NOW(lbl, clk_i, rst_i, pre, post)
`define CSL_ASSERT_NEXT(lbl, clk_i, rst_i, pre, post)
`endif

`endif

// ===== design/csl_pkg.sv =====
// Types, token codes and keyword table shared by the lexer modules.
package csl_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [31:0] number_value;
    logic [2:0]  keyword_index;
    logic [7:0]  punct_first;
    logic [7:0]  punct_second;
    logic        last_of_run;
  } out_item_t;

  // Up to two tokens per input item: a pending token, then a fresh one.
  typedef struct packed {
    logic      a_valid;
    out_item_t a;
    logic      b_valid;
    out_item_t b;
  } push_t;

  localparam int Q_DEPTH = 4;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room;
  } qstat_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_HELD,
    MODE_ERROR
  } lex_mode_t;

  localparam logic [2:0] KIND_NUM     = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_KEYWORD = 3'd2;
  localparam logic [2:0] KIND_PUNCT   = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam int KW_COUNT = 8;

  // Keyword text, first byte in the low byte: return if else for while int sizeof char
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h6E7275746572,
    48'h000000006669,
    48'h000065736C65,
    48'h000000726F66,
    48'h00656C696877,
    48'h000000746E69,
    48'h666F657A6973,
    48'h000072616863
  };
  localparam logic [15:0] KW_LEN [KW_COUNT] = '{
    16'd6, 16'd2, 16'd4, 16'd3, 16'd5, 16'd3, 16'd6, 16'd4
  };

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } kw_hit_t;

  function automatic kw_hit_t kw_lookup(input logic [47:0] prefix, input logic [15:0] len);
    kw_hit_t res;
    res = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
        res.hit = 1'b1;
        res.idx = 3'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== design/csl_core.sv =====
// Lexer state and per-byte token logic: one input item per cycle, taken only when accept is high.
module csl_core #(
  parameter int OFFSET_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  csl_pkg::in_item_t in_item,
  output csl_pkg::push_t    push
);
  import csl_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  lex_mode_t              mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] tok_start_r, tok_start_nxt;
  logic [31:0]            num_acc_r, num_acc_nxt;
  logic [47:0]            prefix_r, prefix_nxt;
  logic [15:0]            id_len_r, id_len_nxt;
  logic [7:0]             held_r, held_nxt;

  logic [7:0] ch;
  logic       is_end;
  logic c_space, c_digit, c_letter, c_alpha, c_alnum, c_punct, c_hold, c_invalid, c_eq;
  logic cont, pair, flush, fresh;
  logic [35:0] num_sum;
  logic [31:0] num_sat;
  logic [15:0] pos_sat, tok_sat;
  kw_hit_t     kw;

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] ext;
    ext = {16'b0, v};
    return (ext[OFFSET_BITS+15:16] != '0) ? 16'hFFFF : ext[15:0];
  endfunction

  assign ch     = in_item.ch;
  assign is_end = in_item.is_end;

  assign c_space   = (ch == 8'h20) || (ch inside {[8'h09:8'h0D]});
  assign c_digit   = ch inside {[8'h30:8'h39]};
  assign c_letter  = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign c_alpha   = c_letter || (ch == CH_USCORE);
  assign c_alnum   = c_alpha || c_digit;
  // underscore starts a name, so it never counts as punctuation here
  assign c_punct   = (ch inside {[8'h21:8'h7E]}) && !c_digit && !c_alpha;
  assign c_hold    = ch inside {CH_EQ, CH_BANG, CH_LT, CH_GT};
  assign c_eq      = (ch == CH_EQ);
  assign c_invalid = !c_space && !c_alpha && !c_digit && !c_punct;

  assign cont  = !is_end && (((mode_r == MODE_NUM) && c_digit) ||
                             ((mode_r == MODE_IDENT) && c_alnum));
  assign pair  = !is_end && (mode_r == MODE_HELD) && c_eq;
  assign flush = !cont && !pair &&
                 (mode_r inside {MODE_NUM, MODE_IDENT, MODE_HELD});
  assign fresh = !is_end && (mode_r != MODE_ERROR) && !cont && !pair;

  // acc*10 + digit as two shifted adds, then clamp to 32 bits
  assign num_sum = {1'b0, num_acc_r, 3'b000} + {3'b000, num_acc_r, 1'b0} + {32'b0, ch[3:0]};
  assign num_sat = (num_sum[35:32] != 4'b0) ? 32'hFFFF_FFFF : num_sum[31:0];

  assign pos_sat = sat16(pos_r);
  assign tok_sat = sat16(tok_start_r);
  assign kw      = kw_lookup(prefix_r, id_len_r);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      if (is_end) begin
        mode_nxt = MODE_IDLE;
      end else if (pair) begin
        mode_nxt = MODE_IDLE;
      end else if (fresh) begin
        if (c_digit) begin
          mode_nxt = MODE_NUM;
        end else if (c_alpha) begin
          mode_nxt = MODE_IDENT;
        end else if (c_punct) begin
          mode_nxt = c_hold ? MODE_HELD : MODE_IDLE;
        end else if (c_space) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
    end
  end

  // token outputs
  always_comb begin
    push = '0;
    if (accept) begin
      if (pair) begin
        push.a_valid        = 1'b1;
        push.a.kind         = KIND_PUNCT;
        push.a.start_offset = tok_sat;
        push.a.token_length = 16'd2;
        push.a.punct_first  = held_r;
        push.a.punct_second = CH_EQ;
      end else if (flush) begin
        push.a_valid        = 1'b1;
        push.a.start_offset = tok_sat;
        case (mode_r)
          MODE_NUM: begin
            push.a.kind         = KIND_NUM;
            push.a.token_length = id_len_r;
            push.a.number_value = num_acc_r;
          end
          MODE_IDENT: begin
            push.a.kind          = kw.hit ? KIND_KEYWORD : KIND_IDENT;
            push.a.keyword_index = kw.hit ? kw.idx : 3'd0;
            push.a.token_length  = id_len_r;
          end
          default: begin
            push.a.kind         = KIND_PUNCT;
            push.a.token_length = 16'd1;
            push.a.punct_first  = held_r;
          end
        endcase
      end

      if (is_end) begin
        push.b_valid        = 1'b1;
        push.b.kind         = KIND_END;
        push.b.start_offset = pos_sat;
      end else if (fresh && c_punct && !c_hold) begin
        push.b_valid        = 1'b1;
        push.b.kind         = KIND_PUNCT;
        push.b.start_offset = pos_sat;
        push.b.token_length = 16'd1;
        push.b.punct_first  = ch;
      end else if (fresh && c_invalid) begin
        push.b_valid        = 1'b1;
        push.b.kind         = KIND_ERROR;
        push.b.start_offset = pos_sat;
        push.b.token_length = 16'd1;
      end

      push.a.last_of_run = !push.b_valid;
      push.b.last_of_run = 1'b1;
    end
  end

  // data state
  always_comb begin
    pos_nxt       = pos_r;
    tok_start_nxt = tok_start_r;
    num_acc_nxt   = num_acc_r;
    prefix_nxt    = prefix_r;
    id_len_nxt    = id_len_r;
    held_nxt      = held_r;
    if (accept) begin
      if (is_end) begin
        pos_nxt       = '0;
        tok_start_nxt = '0;
        num_acc_nxt   = '0;
        prefix_nxt    = '0;
        id_len_nxt    = '0;
        held_nxt      = '0;
      end else begin
        pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
        if (cont) begin
          if (mode_r == MODE_NUM) begin
            num_acc_nxt = num_sat;
          end else begin
            for (int i = 0; i < 6; i++) begin
              if (id_len_r == 16'(i)) begin
                prefix_nxt[8*i +: 8] = prefix_r[8*i +: 8] | ch;
              end
            end
          end
          id_len_nxt = (id_len_r == 16'hFFFF) ? id_len_r : id_len_r + 16'd1;
        end
        if (pair || (flush && (mode_r == MODE_HELD))) begin
          held_nxt = '0;
        end
        if (fresh) begin
          if (c_digit) begin
            tok_start_nxt = pos_r;
            num_acc_nxt   = {28'b0, ch[3:0]};
            id_len_nxt    = 16'd1;
          end else if (c_alpha) begin
            tok_start_nxt = pos_r;
            prefix_nxt    = {40'b0, ch};
            id_len_nxt    = 16'd1;
          end else if (c_punct && c_hold) begin
            tok_start_nxt = pos_r;
            held_nxt      = ch;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      tok_start_r <= '0;
      num_acc_r   <= '0;
      prefix_r    <= '0;
      id_len_r    <= '0;
      held_r      <= '0;
    end else begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      tok_start_r <= tok_start_nxt;
      num_acc_r   <= num_acc_nxt;
      prefix_r    <= prefix_nxt;
      id_len_r    <= id_len_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

// ===== design/csl_outq.sv =====
// Small result queue: up to two tokens in a cycle, at most one out.
module csl_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  csl_pkg::push_t     push,
  input  logic               out_stall,
  output logic               out_valid,
  output csl_pkg::out_item_t out_item,
  output csl_pkg::qstat_t    q_stat
);
  import csl_pkg::*;

  out_item_t         mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [1:0]        n_push;
  logic              pop;
  out_item_t         first;

  assign n_push = {1'b0, push.a_valid} + {1'b0, push.b_valid};
  assign pop    = (count_r != '0) && !out_stall;
  assign first  = push.a_valid ? push.a : push.b;

  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
  assign count_nxt  = count_r + QCNT_W'(n_push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= first;
    end
    if (push.a_valid && push.b_valid) begin
      mem_r[wr_ptr_r + 1'b1] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid    = (count_r != '0);
  assign out_item     = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  // two free slots needed, an item can give two tokens
  assign q_stat.room  = (count_r <= QCNT_W'(Q_DEPTH - 2));

endmodule

// ===== design/c_subset_lexer_top.sv =====
// Top level of the C subset lexer: byte in, tokens out.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_item_t  (ch, is_end)
//   out_    | output    | out_valid/out_stall | out_item_t (one token)
//
// At most one byte is taken per cycle; its tokens enter a four-entry queue the
// same edge. A byte yields zero, one or two tokens; the queue hands out at most
// one token a cycle, so the single output port sets the rate when many bytes
// produce two tokens. in_stall rises when fewer than two queue slots are free.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to idle.
`include "c_subset_lexer_top_defines.svh"

module c_subset_lexer_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  csl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output csl_pkg::out_item_t out_item
);
  import csl_pkg::*;

  logic   accept;
  push_t  push;
  qstat_t q_stat;

  assign in_stall = !q_stat.room;
  assign accept   = in_valid && !in_stall;

  csl_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_item(in_item),
    .push   (push)
  );

  csl_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .q_stat   (q_stat)
  );

  `CSL_ASSERT_NOW(a_push_only_on_accept, clk, rst_n, push.a_valid || push.b_valid, accept)
  `CSL_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, q_stat.count <= QCNT_W'(Q_DEPTH))
  `CSL_ASSERT_NEXT(a_end_gives_token, clk, rst_n, accept && in_item.is_end, out_valid)

endmodule

// ===== tb/c_subset_lexer_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the C subset lexer: byte streams in, token predictor, checker.
module c_subset_lexer_top_test;
  import csl_pkg::*;

  localparam int POS_BITS = 16;
  localparam longint unsigned POS_MAX = (64'd1 << POS_BITS) - 1;
  localparam int LONG_NAME_LEN = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  c_subset_lexer_top #(.OFFSET_BITS(POS_BITS)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // Predicted lexer state
  lex_mode_t       st_mode;
  longint unsigned st_pos;
  longint unsigned st_start;
  logic [15:0]     st_len;
  logic [31:0]     st_acc;
  logic [47:0]     st_prefix;
  logic [7:0]      st_held;

  out_item_t step_toks[$];
  out_item_t pending_tokens[$];
  out_item_t tok_want;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_lexed = 0;
  int mismatches = 0;

  string kw_names [8] = '{"return", "if", "else", "for", "while", "int", "sizeof", "char"};

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_USCORE;
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c > 8'h20 && c < 8'h7F && !is_digit(c) &&
           !(c >= "a" && c <= "z") && !(c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_holdable(logic [7:0] c);
    return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;
  endfunction

  function automatic void lexer_reset();
    st_mode   = MODE_IDLE;
    st_pos    = 0;
    st_start  = 0;
    st_len    = '0;
    st_acc    = '0;
    st_prefix = '0;
    st_held   = '0;
  endfunction

  function automatic void advance_pos();
    if (st_pos < POS_MAX) st_pos++;
  endfunction

  function automatic out_item_t make_tok(logic [2:0] k, longint unsigned start,
                                         longint unsigned len, logic [31:0] val,
                                         logic [2:0] kw, logic [7:0] p1, logic [7:0] p2);
    out_item_t t;
    t.kind          = k;
    t.start_offset  = (start > 64'hFFFF) ? 16'hFFFF : 16'(start);
    t.token_length  = (len > 64'hFFFF) ? 16'hFFFF : 16'(len);
    t.number_value  = val;
    t.keyword_index = kw;
    t.punct_first   = p1;
    t.punct_second  = p2;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  // Keyword only on an exact length match; the prefix holds at most six bytes.
  function automatic out_item_t ident_token();
    logic [47:0] text;
    for (int i = 0; i < 8; i++) begin
      text = '0;
      for (int j = 0; j < kw_names[i].len(); j++) text[8*j +: 8] = kw_names[i][j];
      if (st_len == 16'(kw_names[i].len()) && st_prefix == text)
        return make_tok(KIND_KEYWORD, st_start, st_len, '0, 3'(i), '0, '0);
    end
    return make_tok(KIND_IDENT, st_start, st_len, '0, '0, '0, '0);
  endfunction

  task automatic predict_tokens(input in_item_t it);
    logic [7:0]      c;
    longint unsigned v;
    bit              taken;
    c = it.ch;
    taken = 1'b0;
    step_toks.delete();
    bytes_lexed++;
    if (it.is_end) begin
      case (st_mode)
        MODE_NUM:   step_toks.push_back(make_tok(KIND_NUM, st_start, st_len, st_acc,
                                                 '0, '0, '0));
        MODE_IDENT: step_toks.push_back(ident_token());
        MODE_HELD:  step_toks.push_back(make_tok(KIND_PUNCT, st_start, 1, '0, '0,
                                                 st_held, '0));
        default: ;
      endcase
      step_toks.push_back(make_tok(KIND_END, st_pos, 0, '0, '0, '0, '0));
      lexer_reset();
    end else if (st_mode == MODE_ERROR) begin
      advance_pos();
    end else begin
      case (st_mode)
        MODE_NUM: begin
          if (is_digit(c)) begin
            v = 64'(st_acc) * 10 + 64'(c - "0");
            st_acc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
            if (st_len != 16'hFFFF) st_len++;
            taken = 1'b1;
          end else begin
            step_toks.push_back(make_tok(KIND_NUM, st_start, st_len, st_acc, '0, '0, '0));
            st_mode = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (st_len < 16'd6) st_prefix[8*st_len +: 8] = c;
            if (st_len != 16'hFFFF) st_len++;
            taken = 1'b1;
          end else begin
            step_toks.push_back(ident_token());
            st_mode = MODE_IDLE;
          end
        end
        MODE_HELD: begin
          st_mode = MODE_IDLE;
          if (c == CH_EQ) begin
            step_toks.push_back(make_tok(KIND_PUNCT, st_start, 2, '0, '0, st_held, CH_EQ));
            taken = 1'b1;
          end else begin
            step_toks.push_back(make_tok(KIND_PUNCT, st_start, 1, '0, '0, st_held, '0));
          end
          st_held = '0;
        end
        default: ;
      endcase
      if (!taken && !is_space(c)) begin
        if (is_digit(c)) begin
          st_mode  = MODE_NUM;
          st_start = st_pos;
          st_acc   = 32'(c - "0");
          st_len   = 16'd1;
        end else if (is_alpha(c)) begin
          st_mode   = MODE_IDENT;
          st_start  = st_pos;
          st_prefix = {40'h0, c};
          st_len    = 16'd1;
        end else if (is_punct(c)) begin
          if (is_holdable(c)) begin
            st_mode  = MODE_HELD;
            st_start = st_pos;
            st_held  = c;
          end else begin
            step_toks.push_back(make_tok(KIND_PUNCT, st_pos, 1, '0, '0, c, '0));
          end
        end else begin
          step_toks.push_back(make_tok(KIND_ERROR, st_pos, 1, '0, '0, '0, '0));
          st_mode = MODE_ERROR;
        end
      end
      advance_pos();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1'b1;
    foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
  endtask

  task automatic log_bad(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected kind %0d start %0d len %0d value %0d kw %0d punct %h/%h last %b",
               $time, what, want.kind, want.start_offset, want.token_length,
               want.number_value, want.keyword_index, want.punct_first,
               want.punct_second, want.last_of_run);
      $display("%0t %s: got      kind %0d start %0d len %0d value %0d kw %0d punct %h/%h last %b",
               $time, what, got.kind, got.start_offset, got.token_length,
               got.number_value, got.keyword_index, got.punct_first,
               got.punct_second, got.last_of_run);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_tokens.size() == 0) begin
        log_bad("token with none expected", '0, out_item);
      end else begin
        tok_want = pending_tokens.pop_front();
        if (out_item.kind !== tok_want.kind ||
            out_item.start_offset !== tok_want.start_offset ||
            out_item.token_length !== tok_want.token_length ||
            out_item.number_value !== tok_want.number_value ||
            out_item.keyword_index !== tok_want.keyword_index ||
            out_item.punct_first !== tok_want.punct_first ||
            out_item.punct_second !== tok_want.punct_second ||
            out_item.last_of_run !== tok_want.last_of_run)
          log_bad("token mismatch", tok_want, out_item);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic e);
    in_item_t it;
    it.ch = c;
    it.is_end = e;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_tokens(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Hold the input off until every predicted token has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  function automatic logic [7:0] rand_name_char(bit lead);
    int r;
    r = lead ? $urandom_range(52) : $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_USCORE;
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] c;
    case ($urandom_range(5))
      0: c = CH_EQ;
      1: c = CH_BANG;
      2: c = CH_LT;
      3: c = CH_GT;
      default: begin
        do c = 8'($urandom_range(33, 126)); while (!is_punct(c) || c == CH_USCORE);
      end
    endcase
    return c;
  endfunction

  task automatic send_random_token();
    logic [7:0] word[$];
    int         pick;
    int         n;
    string      kw;
    pick = $urandom_range(99);
    if (pick < 16) begin
      kw = kw_names[$urandom_range(7)];
      for (int i = 0; i < kw.len(); i++) word.push_back(kw[i]);
      // a trailing name char turns it into a plain identifier
      if ($urandom_range(3) == 0) word.push_back(rand_name_char(1'b0));
    end else if (pick < 32) begin
      word.push_back(rand_name_char(1'b1));
      repeat ($urandom_range(9)) word.push_back(rand_name_char(1'b0));
    end else if (pick < 50) begin
      n = ($urandom_range(4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
      repeat (n) word.push_back(8'($urandom_range(48, 57)));
    end else if (pick < 74) begin
      word.push_back(rand_punct());
      if ($urandom_range(1)) word.push_back(CH_EQ);
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(8, 13);
        word.push_back(n == 8 ? 8'h20 : 8'(n));
      end
    end else if (pick < 94) begin
      word.push_back(8'($urandom_range(255)));
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
    foreach (word[i]) send_byte(word[i], 1'b0);
  endtask

  // A keyword, two-byte punctuators, held punctuator before a name, end flush,
  // error after a pending number, ignored bytes, held '=' cut by a bad byte.
  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_text("if a!=9<b");
    send_byte(8'h00, 1'b1);
    send_text("7");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\tzz>==");
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  // One name far past the six kept bytes, then a pair, a space and a lone punctuator.
  task automatic test_long_name();
    idle_pct = 0;
    stall_pct = 0;
    send_text("q");
    repeat (LONG_NAME_LEN - 1) send_byte(rand_name_char(1'b0), 1'b0);
    send_text("== ;");
    send_byte(8'h20, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    int stop;
    idle_pct = idle;
    stall_pct = stall;
    stop = bytes_lexed + count;
    while (bytes_lexed < stop) send_random_token();
  endtask

  initial begin
    lexer_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_long_name();
    test_random_traffic(0, 0, 445);
    test_random_traffic(85, 0, 445);
    test_random_traffic(0, 85, 445);
    test_random_traffic(32, 32, 445);
    send_byte(8'h20, 1'b1);
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
